FILE: rtl/core/kflerp_pkg.sv
package kflerp_pkg;

  localparam int MAX_KEYS_DEF = 64;
  localparam int TIME_W       = 32;
  localparam int VAL_W        = 32;
  localparam int FRAC_BITS    = 16;
  // The fraction reaches exactly one, so it needs one bit above Q0.16.
  localparam int QUO_W        = FRAC_BITS + 1;

  typedef enum logic [1:0] {
    CMD_CLEAR  = 2'd0,
    CMD_APPEND = 2'd1,
    CMD_SAMPLE = 2'd2
  } cmd_t;

  typedef enum logic [2:0] {
    ST_SAMPLED = 3'd0,
    ST_EMPTY   = 3'd1,
    ST_STORED  = 3'd2,
    ST_DROPPED = 3'd3,
    ST_CLEARED = 3'd4
  } status_t;

  typedef struct packed {
    logic [1:0]              command;
    logic [TIME_W-1:0]       time_value;
    logic signed [VAL_W-1:0] value_x;
    logic signed [VAL_W-1:0] value_y;
    logic signed [VAL_W-1:0] value_z;
  } in_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] out_x;
    logic signed [VAL_W-1:0] out_y;
    logic signed [VAL_W-1:0] out_z;
    logic [2:0]              status;
  } out_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] x;
    logic signed [VAL_W-1:0] y;
    logic signed [VAL_W-1:0] z;
  } key_vec_t;

endpackage

FILE: rtl/core/kflerp_frac_div.sv
module kflerp_frac_div
  import kflerp_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [TIME_W-1:0] span,
  input  logic [TIME_W-1:0] delta,
  output logic              busy,
  output logic [QUO_W-1:0]  quo
);

  // Restoring division of (span << 16) by delta, one quotient bit per cycle.
  // Because span never exceeds delta, span >> 1 already lies below delta and
  // only the last QUO_W dividend bits need to be shifted in.
  localparam int STEP_W = $clog2(QUO_W);

  logic              busy_r, busy_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic [TIME_W-1:0] rem_r, rem_nxt;
  logic [TIME_W-1:0] den_r, den_nxt;
  logic              lsb_r, lsb_nxt;
  logic [QUO_W-1:0]  quo_r, quo_nxt;
  logic [TIME_W:0]   shifted;
  logic [TIME_W:0]   diff;
  logic              bit_in;

  always_comb begin
    bit_in   = (step_r == '0) ? lsb_r : 1'b0;
    shifted  = {rem_r, bit_in};
    diff     = shifted - {1'b0, den_r};
    busy_nxt = busy_r;
    step_nxt = step_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    lsb_nxt  = lsb_r;
    quo_nxt  = quo_r;
    if (start) begin
      busy_nxt = 1'b1;
      step_nxt = '0;
      rem_nxt  = {1'b0, span[TIME_W-1:1]};
      lsb_nxt  = span[0];
      den_nxt  = delta;
      quo_nxt  = '0;
    end else if (busy_r) begin
      if (!diff[TIME_W]) begin
        rem_nxt = diff[TIME_W-1:0];
        quo_nxt = {quo_r[QUO_W-2:0], 1'b1};
      end else begin
        rem_nxt = shifted[TIME_W-1:0];
        quo_nxt = {quo_r[QUO_W-2:0], 1'b0};
      end
      step_nxt = step_r + 1'b1;
      if (step_r == STEP_W'(QUO_W - 1)) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      step_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      step_r <= step_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    den_r <= den_nxt;
    lsb_r <= lsb_nxt;
    quo_r <= quo_nxt;
  end

  assign busy = busy_r;
  assign quo  = quo_r;

endmodule

FILE: rtl/core/kflerp_lane.sv
module kflerp_lane
  import kflerp_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  logic signed [VAL_W-1:0] val_a,
  input  logic signed [VAL_W-1:0] val_b,
  input  logic [QUO_W-1:0]        frac,
  output logic                    done,
  output logic signed [VAL_W-1:0] result
);

  // Three stages: difference, product with the fraction, then add back the
  // floor of the product in Q16.16.
  localparam int PROD_W = VAL_W + 1 + QUO_W + 1;

  logic [2:0]               vld_r;
  logic signed [VAL_W:0]    diff_r;
  logic signed [VAL_W-1:0]  a0_r, a1_r;
  logic [QUO_W-1:0]         frac_r;
  logic signed [PROD_W-1:0] prod_r;
  logic signed [VAL_W-1:0]  res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[1:0], start};
    end
  end

  always_ff @(posedge clk) begin
    diff_r <= {val_b[VAL_W-1], val_b} - {val_a[VAL_W-1], val_a};
    a0_r   <= val_a;
    frac_r <= frac;
    prod_r <= PROD_W'(diff_r) * PROD_W'($signed({1'b0, frac_r}));
    a1_r   <= a0_r;
    res_r  <= a1_r + prod_r[FRAC_BITS +: VAL_W];
  end

  assign done   = vld_r[2];
  assign result = res_r;

endmodule

FILE: rtl/core/keyframe_vec3_lerp_sampler.sv
// Keyframe sampler for three-component vectors. Each transaction on the input
// channel carries a command: clear empties the key table, append stores one
// key (time, x, y, z) at the end of the table, and sample returns the vector at
// the given time, linearly interpolated between the two keys around it, or the
// first or last key when the time lies outside their span. Keys are meant to
// be appended in nondecreasing time order. Times are unsigned Q16.16, vector
// components signed Q16.16, and the interpolation fraction is truncated to
// Q1.16. Every input transaction yields exactly one output transaction whose
// status tells what happened; a full table drops an append and reports it.
// The block handles one transaction at a time. Clear and append go straight
// to the done state. A sample that clamps to an end key reads the first key
// time, the last key time if needed, and then the key vector; one that
// interpolates walks the key times one per cycle from the second key until it
// finds the bracketing pair over the single read port of the time memory, then
// reads both key vectors and waits for the fraction divider. The x, y and z
// interpolations run in three parallel multiplier lanes whose outputs are
// merged into one result. A finished result waits in the output register,
// and the next input transaction is taken while it waits.
module keyframe_vec3_lerp_sampler
  import kflerp_pkg::*;
#(
  parameter int MAX_KEYS = MAX_KEYS_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_stall,
  output out_t out_data
);

  localparam int IW = $clog2(MAX_KEYS);
  localparam int CW = $clog2(MAX_KEYS + 1);

  typedef enum logic [10:0] {
    S_IDLE   = 11'b00000000001,
    S_FIRST  = 11'b00000000010,
    S_LAST   = 11'b00000000100,
    S_SCAN   = 11'b00000001000,
    S_LERP_A = 11'b00000010000,
    S_LERP_B = 11'b00000100000,
    S_DIV    = 11'b00001000000,
    S_LANE   = 11'b00010000000,
    S_VAL    = 11'b00100000000,
    S_VAL_W  = 11'b01000000000,
    S_DONE   = 11'b10000000000
  } state_t;

  // Key storage: times and vectors in two memories sharing the write address.
  logic [TIME_W-1:0] time_mem [MAX_KEYS];
  key_vec_t          vec_mem  [MAX_KEYS];

  state_t            state_r, state_nxt;
  logic [CW-1:0]     cnt_r, cnt_nxt;
  logic [TIME_W-1:0] t_r, t_nxt;
  logic [TIME_W-1:0] prev_r, prev_nxt;
  logic [IW-1:0]     scan_r, scan_nxt;
  logic [IW-1:0]     i0_r, i0_nxt;
  logic [IW-1:0]     i1_r, i1_nxt;
  key_vec_t          a_r, a_nxt;
  out_t              res_r, res_nxt;
  out_t              out_r;
  logic              out_valid_r;

  logic              wr_en;
  logic [IW-1:0]     last_idx;
  logic [IW-1:0]     t_addr;
  logic [TIME_W-1:0] t_q;
  logic              v_rd_en;
  logic [IW-1:0]     v_addr;
  key_vec_t          v_q;
  logic              accept;
  logic              push_out;

  logic              div_start;
  logic [TIME_W-1:0] div_span;
  logic [TIME_W-1:0] div_delta;
  logic              div_busy;
  logic [QUO_W-1:0]  frac;

  logic              lane_start;
  logic [2:0]        lane_done;
  key_vec_t          lane_res;

  assign accept   = in_valid && (state_r == S_IDLE);
  assign in_stall = (state_r != S_IDLE);
  assign last_idx = IW'(cnt_r - 1'b1);
  assign push_out = (state_r == S_DONE) && (!out_valid_r || !out_stall);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      time_mem[IW'(cnt_r)] <= in_data.time_value;
      vec_mem[IW'(cnt_r)]  <= '{x: in_data.value_x, y: in_data.value_y, z: in_data.value_z};
    end
    t_q <= time_mem[t_addr];
    if (v_rd_en) begin
      v_q <= vec_mem[v_addr];
    end
  end

  always_comb begin
    state_nxt  = state_r;
    cnt_nxt    = cnt_r;
    t_nxt      = t_r;
    prev_nxt   = prev_r;
    scan_nxt   = scan_r;
    i0_nxt     = i0_r;
    i1_nxt     = i1_r;
    a_nxt      = a_r;
    res_nxt    = res_r;
    wr_en      = 1'b0;
    t_addr     = '0;
    v_rd_en    = 1'b0;
    v_addr     = i0_r;
    div_start  = 1'b0;
    div_span   = t_r - prev_r;
    div_delta  = t_q - prev_r;
    lane_start = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          res_nxt = '0;
          t_nxt   = in_data.time_value;
          case (in_data.command)
            CMD_CLEAR: begin
              cnt_nxt        = '0;
              res_nxt.status = ST_CLEARED;
              state_nxt      = S_DONE;
            end
            CMD_APPEND: begin
              if (cnt_r == CW'(MAX_KEYS)) begin
                res_nxt.status = ST_DROPPED;
              end else begin
                wr_en          = 1'b1;
                cnt_nxt        = cnt_r + 1'b1;
                res_nxt.status = ST_STORED;
              end
              state_nxt = S_DONE;
            end
            default: begin
              // Both codes with the upper bit set sample the table.
              if (cnt_r == '0) begin
                res_nxt.status = ST_EMPTY;
                state_nxt      = S_DONE;
              end else begin
                res_nxt.status = ST_SAMPLED;
                state_nxt      = S_FIRST;
              end
            end
          endcase
        end
      end
      S_FIRST: begin
        // The first key time is on the read port now.
        prev_nxt = t_q;
        t_addr   = last_idx;
        if (cnt_r == CW'(1) || t_r <= t_q) begin
          i0_nxt    = '0;
          state_nxt = S_VAL;
        end else begin
          state_nxt = S_LAST;
        end
      end
      S_LAST: begin
        t_addr = IW'(1);
        if (t_r >= t_q) begin
          i0_nxt    = last_idx;
          state_nxt = S_VAL;
        end else begin
          scan_nxt  = IW'(1);
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        // The time of key scan_r is on the read port; the next one is fetched.
        t_addr = scan_r + 1'b1;
        if (t_r <= t_q) begin
          i0_nxt = scan_r - 1'b1;
          i1_nxt = scan_r;
          if (t_q > prev_r && t_r >= prev_r) begin
            div_start = 1'b1;
            state_nxt = S_LERP_A;
          end else begin
            state_nxt = S_VAL;
          end
        end else begin
          prev_nxt = t_q;
          scan_nxt = scan_r + 1'b1;
        end
      end
      S_LERP_A: begin
        v_rd_en   = 1'b1;
        v_addr    = i0_r;
        state_nxt = S_LERP_B;
      end
      S_LERP_B: begin
        v_rd_en   = 1'b1;
        v_addr    = i1_r;
        a_nxt     = v_q;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        // The later key stays on the read port until the lanes take it.
        if (!div_busy) begin
          lane_start = 1'b1;
          state_nxt  = S_LANE;
        end
      end
      S_LANE: begin
        if (&lane_done) begin
          res_nxt.out_x = lane_res.x;
          res_nxt.out_y = lane_res.y;
          res_nxt.out_z = lane_res.z;
          state_nxt     = S_DONE;
        end
      end
      S_VAL: begin
        v_rd_en   = 1'b1;
        v_addr    = i0_r;
        state_nxt = S_VAL_W;
      end
      S_VAL_W: begin
        res_nxt.out_x = v_q.x;
        res_nxt.out_y = v_q.y;
        res_nxt.out_z = v_q.z;
        state_nxt     = S_DONE;
      end
      S_DONE: begin
        if (push_out) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  kflerp_frac_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .span  (div_span),
    .delta (div_delta),
    .busy  (div_busy),
    .quo   (frac)
  );

  kflerp_lane u_lane_x (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (lane_start),
    .val_a  (a_r.x),
    .val_b  (v_q.x),
    .frac   (frac),
    .done   (lane_done[0]),
    .result (lane_res.x)
  );

  kflerp_lane u_lane_y (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (lane_start),
    .val_a  (a_r.y),
    .val_b  (v_q.y),
    .frac   (frac),
    .done   (lane_done[1]),
    .result (lane_res.y)
  );

  kflerp_lane u_lane_z (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (lane_start),
    .val_a  (a_r.z),
    .val_b  (v_q.z),
    .frac   (frac),
    .done   (lane_done[2]),
    .result (lane_res.z)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      if (push_out) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    t_r    <= t_nxt;
    prev_r <= prev_nxt;
    scan_r <= scan_nxt;
    i0_r   <= i0_nxt;
    i1_r   <= i1_nxt;
    a_r    <= a_nxt;
    res_r  <= res_nxt;
    if (push_out) begin
      out_r <= res_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule
